// ===== hdl/tbbc_pkg.sv =====
// Shared types and constants for the tick, beat and bar clock.
`default_nettype none
package tbbc_pkg;

    localparam int unsigned TIME_W  = 63;
    localparam int unsigned TICK_W  = 10;
    localparam int unsigned BEAT_W  = 6;
    localparam int unsigned BAR_W   = 32;
    localparam int unsigned TPB_W   = 11;
    localparam int unsigned BPB_W   = 7;
    localparam int unsigned PER_W   = 32;
    localparam int unsigned IDX_W   = 2;

    localparam logic [TPB_W-1:0] TICK_LIMIT = 11'd1024;
    localparam logic [BPB_W-1:0] BEAT_LIMIT = 7'd64;

    localparam logic [PER_W-1:0] PERIOD_RST = 32'd3906250;
    localparam logic [TPB_W-1:0] TPB_RST    = 11'd128;
    localparam logic [BPB_W-1:0] BPB_RST    = 7'd4;

    localparam logic [IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] REG_TPB    = 2'd1;
    localparam logic [IDX_W-1:0] REG_BPB    = 2'd2;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        logic [BAR_W-1:0]  bar;
        logic [BEAT_W-1:0] beat;
        logic [TICK_W-1:0] tick;
        logic              beat_ev;
        logic              bar_ev;
    } cnt_t;

endpackage
`default_nettype wire

// ===== hdl/tbbc_alu.sv =====
// Shared 63-bit add and subtract unit used for every time comparison and update.
`default_nettype none
module tbbc_alu
    import tbbc_pkg::*;
(
    input  alu_op_t           op,
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output logic [TIME_W-1:0] result,
    output logic              borrow
);

    logic [TIME_W:0] sum;

    always_comb
    begin
        if (op == ALU_SUB)
        begin
            sum = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            sum = {1'b0, a} + {1'b0, b};
        end
    end

    assign result = sum[TIME_W-1:0];
    assign borrow = (op == ALU_SUB) && sum[TIME_W];

endmodule
`default_nettype wire

// ===== hdl/tbbc_count.sv =====
// Tick, beat and bar counters with their wrap flags.
`default_nettype none
module tbbc_count
    import tbbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             step,
    input  logic [TPB_W-1:0] tpb_lim,
    input  logic [BPB_W-1:0] bpb_lim,
    output cnt_t             cnt
);

    cnt_t             cnt_reg;
    cnt_t             cnt_next;
    logic [TPB_W-1:0] tick_inc;
    logic [BPB_W-1:0] beat_inc;

    always_comb
    begin
        tick_inc = {1'b0, cnt_reg.tick} + TPB_W'(1);
        beat_inc = {1'b0, cnt_reg.beat} + BPB_W'(1);
        cnt_next = cnt_reg;
        if (clear)
        begin
            cnt_next.tick    = '0;
            cnt_next.beat    = '0;
            cnt_next.bar     = '0;
            cnt_next.beat_ev = 1'b1;
            cnt_next.bar_ev  = 1'b1;
        end
        else if (step)
        begin
            cnt_next.beat_ev = 1'b0;
            cnt_next.bar_ev  = 1'b0;
            cnt_next.tick    = tick_inc[TICK_W-1:0];
            if (tick_inc >= tpb_lim)
            begin
                cnt_next.tick    = '0;
                cnt_next.beat_ev = 1'b1;
                cnt_next.beat    = beat_inc[BEAT_W-1:0];
                if (beat_inc >= bpb_lim)
                begin
                    cnt_next.beat   = '0;
                    cnt_next.bar_ev = 1'b1;
                    cnt_next.bar    = cnt_reg.bar + BAR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule
`default_nettype wire

// ===== hdl/tick_beat_bar_clock_core.sv =====
// Top level of the tick, beat and bar clock: sequencer, time registers and ports.
// An input word with tuser set, or the first word after reset, restarts the clock at
// the given time and yields one word with all flags set, in the cycle after the
// input. Otherwise the clock catches up one tick per whole tick period elapsed, at
// most MAX_CATCHUP ticks per input word; each tick runs through STEP, DIFF, CMP and
// WAIT states, since the one shared 63-bit adder is used in turn for the elapsed
// time, the period compare and the last-tick update. An input owing no tick ends
// after DIFF and CMP with no output. The input is not ready until the previous word
// has finished. Configuration writes are taken in any cycle and should be made idle.
`default_nettype none
module tick_beat_bar_clock_core
    import tbbc_pkg::*;
#(
    parameter int unsigned MAX_CATCHUP = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    // tdata: now_ns[62:0], zero[63]
    input  logic [63:0]      s_axis_tdata,
    // tuser: action[0]
    input  logic             s_axis_tuser,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: tick_index[9:0], beat_index[15:10], bar_index[47:16]
    output logic [47:0]      m_axis_tdata,
    // tuser: beat_event[0], bar_event[1], slow_tick_event[2]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [PER_W-1:0] cfg_data
);

    localparam int unsigned N_W = $clog2(MAX_CATCHUP + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CMP,
        ST_WAIT,
        ST_STEP
    } state_t;

    state_t            state_reg;
    logic [PER_W-1:0]  period_reg;
    logic [TPB_W-1:0]  tpb_reg;
    logic [BPB_W-1:0]  bpb_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] diff_reg;
    logic              behind_reg;
    logic              pending_reg;
    logic              held_reg;
    logic              cont_reg;
    logic [N_W-1:0]    n_reg;
    logic [47:0]       tdata_reg;
    logic [2:0]        tuser_reg;
    logic              tlast_reg;
    logic              tvalid_reg;

    alu_op_t           alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_res;
    logic              alu_borrow;
    logic [PER_W-1:0]  period_eff;
    logic [TPB_W-1:0]  tpb_lim;
    logic [BPB_W-1:0]  bpb_lim;
    logic              in_acc;
    logic              restart;
    logic              cnt_clear;
    logic              cnt_step;
    logic              more;
    cnt_t              cnt;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign restart    = s_axis_tuser || pending_reg;
    assign period_eff = (period_reg == '0) ? PER_W'(1) : period_reg;
    assign tpb_lim    = (tpb_reg > TICK_LIMIT) ? TICK_LIMIT : tpb_reg;
    assign bpb_lim    = (bpb_reg > BEAT_LIMIT) ? BEAT_LIMIT : bpb_reg;
    assign cnt_clear  = in_acc && restart;
    assign cnt_step   = (state_reg == ST_STEP);
    assign more       = !behind_reg && !alu_borrow && (n_reg < N_W'(MAX_CATCHUP));

    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = now_reg;
        alu_b  = last_time_reg;
        case (state_reg)
            ST_CMP:
            begin
                alu_a = diff_reg;
                alu_b = TIME_W'(period_eff);
            end
            ST_STEP:
            begin
                alu_op = ALU_ADD;
                alu_a  = last_time_reg;
                alu_b  = TIME_W'(period_eff);
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    tbbc_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    tbbc_count u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cnt_clear),
        .step    (cnt_step),
        .tpb_lim (tpb_lim),
        .bpb_lim (bpb_lim),
        .cnt     (cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            tpb_reg    <= TPB_RST;
            bpb_reg    <= BPB_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PERIOD: period_reg <= cfg_data;
                REG_TPB:    tpb_reg    <= cfg_data[TPB_W-1:0];
                REG_BPB:    bpb_reg    <= cfg_data[BPB_W-1:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_time_reg <= '0;
            pending_reg   <= 1'b1;
            held_reg      <= 1'b0;
            cont_reg      <= 1'b0;
            behind_reg    <= 1'b0;
            n_reg         <= '0;
            tvalid_reg    <= 1'b0;
            tlast_reg     <= 1'b0;
            now_reg       <= '0;
            diff_reg      <= '0;
            tdata_reg     <= '0;
            tuser_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        now_reg <= s_axis_tdata[TIME_W-1:0];
                        n_reg   <= '0;
                        if (restart)
                        begin
                            last_time_reg <= s_axis_tdata[TIME_W-1:0];
                            pending_reg   <= 1'b0;
                            tdata_reg     <= '0;
                            tuser_reg     <= 3'b111;
                            tlast_reg     <= 1'b1;
                            tvalid_reg    <= 1'b1;
                            cont_reg      <= 1'b0;
                            state_reg     <= ST_WAIT;
                        end
                        else
                        begin
                            held_reg  <= 1'b0;
                            state_reg <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF:
                begin
                    diff_reg   <= alu_res;
                    behind_reg <= alu_borrow;
                    state_reg  <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (held_reg)
                    begin
                        tdata_reg  <= {cnt.bar, cnt.beat, cnt.tick};
                        tuser_reg  <= {cnt.tick[1:0] == 2'b00, cnt.bar_ev, cnt.beat_ev};
                        tlast_reg  <= !more;
                        tvalid_reg <= 1'b1;
                        cont_reg   <= more;
                        state_reg  <= ST_WAIT;
                    end
                    else if (more)
                    begin
                        state_reg <= ST_STEP;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        tvalid_reg <= 1'b0;
                        state_reg  <= cont_reg ? ST_STEP : ST_IDLE;
                    end
                end
                ST_STEP:
                begin
                    last_time_reg <= alu_res;
                    n_reg         <= n_reg + N_W'(1);
                    held_reg      <= 1'b1;
                    state_reg     <= ST_DIFF;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;
    assign m_axis_tlast  = tlast_reg;
    assign m_axis_tvalid = tvalid_reg;

endmodule
`default_nettype wire

// ===== hdl/tbbc_checker.sv =====
// Port-level checks for the tick, beat and bar clock, bound to the top level.
`default_nettype none
module tbbc_checker
    import tbbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // A stalled output word must hold its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // The block works on one input word at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A beat event always lands on tick zero.
    a_beat_tick: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[9:0] == 10'd0)
        else $error("beat event with nonzero tick index");

    // A bar event is also a beat event and lands on beat zero.
    a_bar_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && m_axis_tdata[15:10] == 6'd0)
        else $error("bar event without beat event at beat zero");

    // The slow tick flag follows the low tick index bits.
    a_slow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[2] == (m_axis_tdata[1:0] == 2'b00))
        else $error("slow tick flag does not match tick index");

endmodule

bind tick_beat_bar_clock_core tbbc_checker u_tbbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the tick, beat and bar clock core, with a built-in tempo predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tbbc_pkg::*;

    localparam int unsigned CATCHUP_MAX   = 16;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned PHASE_WORDS   = 58;

    localparam logic [IDX_W-1:0]  REG_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_HALF  = 63'h4000_0000_0000_0000;
    localparam logic [TIME_W-1:0] SAFE_TOP   = 63'h7F00_0000_0000_0000;
    localparam logic [PER_W-1:0]  PERIOD_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [BEAT_W-1:0] beat;
        logic [BAR_W-1:0]  bar;
        logic              beat_ev;
        logic              bar_ev;
        logic              slow_ev;
        logic              last;
    } tick_word_t;

    typedef struct packed {
        logic              restart;
        logic [TIME_W-1:0] now_ns;
    } time_word_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic [63:0]      s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [47:0]      m_axis_tdata;
    logic [2:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index     = '0;
    logic [PER_W-1:0] cfg_data      = '0;

    tick_beat_bar_clock_core #(
        .MAX_CATCHUP(CATCHUP_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor copy of the registers and the counting state.
    logic [PER_W-1:0]  period_reg   = PERIOD_RST;
    logic [TPB_W-1:0]  tpb_reg      = TPB_RST;
    logic [BPB_W-1:0]  bpb_reg      = BPB_RST;
    logic [TIME_W-1:0] last_tick_at = '0;
    logic [TICK_W-1:0] tick_cnt     = '0;
    logic [BEAT_W-1:0] beat_cnt     = '0;
    logic [BAR_W-1:0]  bar_cnt      = '0;
    logic              restart_due  = 1'b1;

    time_word_t  time_words_q[$];
    tick_word_t  tick_words_due[$];
    time_word_t  cur_word;
    logic [TIME_W-1:0] sim_now = '0;

    logic        in_idle_on  = 1'b1;
    logic        out_idle_on = 1'b1;
    logic        src_busy;
    int unsigned src_wait    = 0;
    int unsigned sink_wait   = 0;
    int unsigned n_queued    = 0;
    int unsigned n_taken     = 0;
    int unsigned n_checked   = 0;
    int unsigned n_restarts  = 0;
    int unsigned n_settings  = 0;
    int unsigned n_fail      = 0;
    int unsigned n_cycles    = 0;
    tick_word_t  seen;
    tick_word_t  want;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_wait(input logic enabled);
        return enabled ? $urandom_range(0, 9) : 0;
    endfunction

    function automatic string show_word(input tick_word_t w);
        return $sformatf("tick=%0d beat=%0d bar=%0d beat_ev=%b bar_ev=%b slow=%b last=%b",
                         w.tick, w.beat, w.bar, w.beat_ev, w.bar_ev, w.slow_ev, w.last);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [TIME_W-1:0] r;
        r = {$urandom, $urandom};
        if (r[62:56] == 7'h7F)
            r[56] = 1'b0;
        return r;
    endfunction

    task automatic advance_tempo_clock(input time_word_t w);
        logic [63:0]       step_ns;
        logic [TPB_W-1:0]  tpb;
        logic [BPB_W-1:0]  bpb;
        logic [TPB_W-1:0]  t;
        logic [BPB_W-1:0]  b;
        tick_word_t        tw;
        int unsigned       n;
        step_ns = (period_reg == '0) ? 64'd1 : {32'd0, period_reg};
        tpb = (tpb_reg > TICK_LIMIT) ? TICK_LIMIT : tpb_reg;
        bpb = (bpb_reg > BEAT_LIMIT) ? BEAT_LIMIT : bpb_reg;
        if (w.restart || restart_due) begin
            last_tick_at = w.now_ns;
            tick_cnt = '0;
            beat_cnt = '0;
            bar_cnt = '0;
            restart_due = 1'b0;
            tw = '0;
            tw.beat_ev = 1'b1;
            tw.bar_ev = 1'b1;
            tw.slow_ev = 1'b1;
            tw.last = 1'b1;
            tick_words_due = {tick_words_due, tw};
            n_restarts++;
            return;
        end
        n = 0;
        while (n < CATCHUP_MAX && w.now_ns >= last_tick_at &&
               ({1'b0, w.now_ns} - {1'b0, last_tick_at}) >= step_ns) begin
            tw = '0;
            t = {1'b0, tick_cnt} + 1'b1;
            last_tick_at = last_tick_at + step_ns[TIME_W-1:0];
            if (t >= tpb) begin
                b = {1'b0, beat_cnt} + 1'b1;
                t = '0;
                tw.beat_ev = 1'b1;
                if (b >= bpb) begin
                    b = '0;
                    tw.bar_ev = 1'b1;
                    bar_cnt = bar_cnt + 1'b1;
                end
                beat_cnt = b[BEAT_W-1:0];
            end
            tick_cnt = t[TICK_W-1:0];
            tw.tick = tick_cnt;
            tw.beat = beat_cnt;
            tw.bar = bar_cnt;
            tw.slow_ev = (tick_cnt[1:0] == 2'b00);
            tick_words_due = {tick_words_due, tw};
            n++;
        end
        if (n > 0) begin
            tw = tick_words_due[$];
            tw.last = 1'b1;
            tick_words_due[tick_words_due.size() - 1] = tw;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else begin
            src_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                advance_tempo_clock(cur_word);
                n_taken++;
                src_busy = 1'b0;
                src_wait = draw_wait(in_idle_on);
            end
            if (!src_busy) begin
                if (src_wait != 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (time_words_q.size() != 0) begin
                    cur_word = time_words_q.pop_front();
                    s_axis_tdata <= {1'b0, cur_word.now_ns};
                    s_axis_tuser <= cur_word.restart;
                    s_axis_tvalid <= 1'b1;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.tick = m_axis_tdata[9:0];
                seen.beat = m_axis_tdata[15:10];
                seen.bar = m_axis_tdata[47:16];
                seen.beat_ev = m_axis_tuser[0];
                seen.bar_ev = m_axis_tuser[1];
                seen.slow_ev = m_axis_tuser[2];
                seen.last = m_axis_tlast;
                n_checked++;
                if (tick_words_due.size() == 0) begin
                    if (n_fail < 10)
                        $display("[%0t] unexpected word: %s", $realtime, show_word(seen));
                    n_fail++;
                end
                else begin
                    want = tick_words_due.pop_front();
                    if (seen !== want) begin
                        if (n_fail < 10)
                            $display("[%0t] mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show_word(want), show_word(seen));
                        n_fail++;
                    end
                end
                sink_wait = draw_wait(out_idle_on);
            end
            if (sink_wait != 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected.",
                     n_cycles, tick_words_due.size());
            $display("** tick_beat_bar_clock_core: FAILED **");
            $finish;
        end
    end

    task automatic queue_time_word(input logic restart, input logic [TIME_W-1:0] now);
        time_word_t w;
        w.restart = restart;
        w.now_ns = now;
        time_words_q = {time_words_q, w};
        n_queued++;
        if (restart || now > sim_now)
            sim_now = now;
    endtask

    task automatic queue_random_time_word();
        logic [63:0] step_ns;
        logic [63:0] ahead;
        int unsigned pick;
        int unsigned k;
        step_ns = (period_reg == '0) ? 64'd1 : {32'd0, period_reg};
        pick = $urandom_range(0, 99);
        if (pick < 8 || sim_now > SAFE_TOP) begin
            queue_time_word(1'b1, rand_time());
        end
        else if (pick < 14) begin
            if (sim_now > 1000)
                queue_time_word(1'b0, sim_now - $urandom_range(1, 1000));
            else
                queue_time_word(1'b0, '0);
        end
        else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                k = 0;
            else if (pick < 7)
                k = $urandom_range(1, 4);
            else
                k = $urandom_range(5, 24);
            ahead = k * step_ns + $urandom_range(0, step_ns - 1);
            queue_time_word(1'b0, sim_now + ahead[TIME_W-1:0]);
        end
    endtask

    task automatic wait_clock_idle();
        while (n_taken != n_queued || tick_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clock_reg(input logic [IDX_W-1:0] idx, input logic [PER_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PERIOD: period_reg = data;
            REG_TPB:    tpb_reg = data[TPB_W-1:0];
            REG_BPB:    bpb_reg = data[BPB_W-1:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_tempo(input logic [PER_W-1:0] period, input logic [PER_W-1:0] tpb,
                             input logic [PER_W-1:0] bpb);
        wait_clock_idle();
        write_clock_reg(REG_PERIOD, period);
        write_clock_reg(REG_TPB, tpb);
        write_clock_reg(REG_BPB, bpb);
        n_settings++;
    endtask

    initial begin
        int unsigned ph;
        int unsigned i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first word after reset restarts even without the restart flag.
        queue_time_word(1'b0, 63'd1000);
        queue_time_word(1'b0, 63'd1000 + 63'd3 * PERIOD_RST);
        queue_time_word(1'b0, 63'd1000 + 63'd3 * PERIOD_RST);
        queue_time_word(1'b0, 63'd500);
        queue_time_word(1'b1, TIME_MAX);
        queue_time_word(1'b0, TIME_MAX);
        queue_time_word(1'b1, '0);

        set_tempo(32'd1, 32'd1, 32'd1);
        queue_time_word(1'b0, 63'd5);
        queue_time_word(1'b0, 63'd100);
        queue_time_word(1'b0, 63'd100);

        set_tempo(32'd0, 32'd0, 32'd0);
        queue_time_word(1'b0, 63'd110);
        queue_time_word(1'b0, 63'd120);

        set_tempo(PERIOD_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_time_word(1'b1, '0);
        queue_time_word(1'b0, TIME_MAX);
        queue_time_word(1'b0, TIME_MAX);
        queue_time_word(1'b1, TIME_HALF);
        queue_time_word(1'b0, TIME_HALF + 63'd5 * PERIOD_MAX);

        set_tempo(32'd7, 32'd1024, 32'd64);
        queue_time_word(1'b0, TIME_HALF + 63'd5 * PERIOD_MAX + 63'd28);

        // Lowering ticks per beat below the current count wraps on the next tick.
        set_tempo(32'd7, 32'd2, 32'd2);
        queue_time_word(1'b0, TIME_HALF + 63'd5 * PERIOD_MAX + 63'd49);

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_tempo($urandom_range(1, 50), $urandom_range(1, 6), $urandom_range(1, 4));
                1: set_tempo(PERIOD_MAX, 32'd1024, 32'd64);
                2: set_tempo($urandom, ($urandom & 32'hFFFF_F800) | 32'd3,
                             ($urandom & 32'hFFFF_FF80) | 32'd2);
                3: begin
                    set_tempo(32'd0, $urandom_range(0, 2047), $urandom_range(0, 127));
                    write_clock_reg(REG_UNUSED, $urandom);
                end
                4: set_tempo($urandom_range(1, 1000), $urandom_range(1, 16),
                             $urandom_range(1, 8));
                default: set_tempo(PERIOD_RST, $urandom_range(1, 3), 32'd64);
            endcase
            if (ph == 2) begin
                in_idle_on = 1'b0;
                out_idle_on = 1'b0;
            end
            else begin
                in_idle_on = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (ph == 0)
                queue_time_word(1'b1, rand_time());
            for (i = 0; i < PHASE_WORDS; i++)
                queue_random_time_word();
        end

        wait_clock_idle();
        if (tick_words_due.size() != 0)
            n_fail += tick_words_due.size();
        $display("Sent %0d time words (%0d restarts) under %0d register settings.",
                 n_taken, n_restarts, n_settings);
        $display("Checked %0d tick words in %0d cycles, %0d failures.",
                 n_checked, n_cycles, n_fail);
        if (n_fail == 0)
            $display("** tick_beat_bar_clock_core: PASSED **");
        else
            $display("** tick_beat_bar_clock_core: FAILED **");
        $finish;
    end

endmodule

// ===== tick_beat_bar_clock_core.f =====
hdl/tbbc_pkg.sv
hdl/tbbc_alu.sv
hdl/tbbc_count.sv
hdl/tick_beat_bar_clock_core.sv
hdl/tbbc_checker.sv
tb/sv/tb_top.sv
